// ===== design/bf3_pkg.sv =====
// bf3_pkg: shared widths, constants and types for the 3x3 box filter
// no dependencies
`timescale 1ns / 1ps

package bf3_pkg;

   localparam int PIX_W       = 8;
   localparam int COL_SUM_W   = 10;
   localparam int BOX_SUM_W   = 12;
   localparam int RECIP_W     = 21;
   localparam int PROD_FULL_W = BOX_SUM_W + RECIP_W;
   localparam int PROD_W      = 32;
   localparam int VAL_W       = 16;
   localparam int FRAME_W_W   = 11;
   localparam int FRAME_H_W   = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int ROW_W       = 13;
   localparam int OUT_ROW_W   = 12;

   // ceil(2^24 / 9): sum * 256 / 9 == (sum * RECIP) >> 16 for sums up to 9 * 255
   localparam logic [RECIP_W-1:0]   RECIP        = 21'd1864136;
   localparam logic [FRAME_H_W-1:0] HEIGHT_MAX   = 13'd4096;
   localparam logic [FRAME_W_W-1:0] WIDTH_RESET  = 11'd256;
   localparam logic [FRAME_H_W-1:0] HEIGHT_RESET = 13'd256;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic fill;
      logic shift;
      logic use_new;
   } win_ctrl_type;

endpackage

// ===== design/bf3_cell.sv =====
// bf3_cell: one window column cell holding a vertical three-pixel sum
// depends on bf3_pkg
`timescale 1ns / 1ps

module bf3_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  bf3_pkg::win_ctrl_type           ctrl,
   input  logic [bf3_pkg::COL_SUM_W-1:0]   new_sum,
   input  logic [bf3_pkg::COL_SUM_W-1:0]   shift_in,
   output logic [bf3_pkg::COL_SUM_W-1:0]   col_sum
);
   import bf3_pkg::*;

   logic [COL_SUM_W-1:0] sum_ff;
   logic [COL_SUM_W-1:0] sum_in;

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.fill) begin
         sum_in = new_sum;
      end else if (ctrl.shift) begin
         sum_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign col_sum = sum_ff;

endmodule

// ===== design/bf3_window.sv =====
// bf3_window: chain of three column cells and the nine-tap box sum
// depends on bf3_pkg and bf3_cell
`timescale 1ns / 1ps

module bf3_window (
   input  logic                            clock,
   input  logic                            reset,
   input  bf3_pkg::win_ctrl_type           ctrl,
   input  logic [bf3_pkg::PIX_W-1:0]       top,
   input  logic [bf3_pkg::PIX_W-1:0]       mid,
   input  logic [bf3_pkg::PIX_W-1:0]       bot,
   output logic [bf3_pkg::BOX_SUM_W-1:0]   box_sum
);
   import bf3_pkg::*;

   logic [COL_SUM_W-1:0] new_sum;
   logic [COL_SUM_W-1:0] col_sum [3];
   logic [COL_SUM_W-1:0] chain_in [3];
   logic [BOX_SUM_W-1:0] sum_old;
   logic [BOX_SUM_W-1:0] sum_new;

   assign new_sum = COL_SUM_W'(top) + COL_SUM_W'(mid) + COL_SUM_W'(bot);

   // newest column enters at cell 2 and moves toward cell 0
   assign chain_in[2] = new_sum;
   assign chain_in[1] = col_sum[2];
   assign chain_in[0] = col_sum[1];

   for (genvar i = 0; i < 3; i++) begin : g_cell
      bf3_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .new_sum  (new_sum),
         .shift_in (chain_in[i]),
         .col_sum  (col_sum[i])
      );
   end

   // right edge replicated: left, centre, centre again
   assign sum_old = BOX_SUM_W'(col_sum[1]) + (BOX_SUM_W'(col_sum[2]) << 1);
   // window after the shift: old cells 1 and 2 plus the new column
   assign sum_new = BOX_SUM_W'(col_sum[1]) + BOX_SUM_W'(col_sum[2]) + BOX_SUM_W'(new_sum);

   assign box_sum = ctrl.use_new ? sum_new : sum_old;

endmodule

// ===== design/bf3_scaler.sv =====
// bf3_scaler: registered multiply by the reciprocal of nine, 8.8 result
// depends on bf3_pkg
`timescale 1ns / 1ps

module bf3_scaler (
   input  logic                            clock,
   input  logic                            enable,
   input  logic [bf3_pkg::BOX_SUM_W-1:0]   box_sum,
   output logic [bf3_pkg::VAL_W-1:0]       value
);
   import bf3_pkg::*;

   logic [PROD_FULL_W-1:0] prod_full;
   logic [PROD_W-1:0]      prod_ff;
   logic [PROD_W-1:0]      prod_in;

   assign prod_full = PROD_FULL_W'(box_sum) * PROD_FULL_W'(RECIP);
   assign prod_in   = prod_full[PROD_W-1:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   assign value = prod_ff[PROD_W-1:PROD_W-VAL_W];

endmodule

// ===== design/box_filter_3x3_clamped_edges.sv =====
// 3x3 box filter with replicated edges over a raster pixel stream
// a result leaves through stage 1, stage 2 and the output register after the transfer that completes it,
// which comes frame_width + 1 transfers after its own pixel
// throughput: one transfer per cycle unless stalled; line store reads and writes may overlap
// reset: synchronous; width and height return to 256, counters and window clear,
// the line store keeps its contents
`timescale 1ns / 1ps

module box_filter_3x3_clamped_edges #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // pixel_value
   input  logic                             req_tuser,   // drain
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,   // smoothed_value
   output logic                             rsp_tlast,   // row_end
   output logic                             rsp_tuser,   // frame_end
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [bf3_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bf3_pkg::*;

   localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int EW    = (WID_W > FRAME_W_W) ? WID_W : FRAME_W_W;

   localparam logic [1:0] PHASE_TAKE  = 2'd0;
   localparam logic [1:0] PHASE_FLUSH = 2'd1;
   localparam logic [1:0] PHASE_FINAL = 2'd2;

   localparam logic [1:0] KIND_FILL0 = 2'd0;
   localparam logic [1:0] KIND_PIX   = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;
   localparam logic [1:0] KIND_FINAL = 2'd3;

   // configuration
   logic [FRAME_W_W-1:0] frame_width_ff;
   logic [FRAME_H_W-1:0] frame_height_ff;
   logic [EW-1:0]        fw_ext;
   logic [EW-1:0]        eff_w;
   logic [FRAME_H_W-1:0] eff_h;

   // input side counters
   logic [1:0]       phase_ff, phase_in;
   logic [IDX_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;

   // output side counters
   logic [IDX_W-1:0]     out_col_ff, out_col_in;
   logic [OUT_ROW_W-1:0] out_row_ff, out_row_in;

   // stage 1
   logic                 s1_v_ff;
   logic [1:0]           s1_kind_ff;
   logic [IDX_W-1:0]     s1_x_ff;
   logic [PIX_W-1:0]     s1_pix_ff;
   logic                 s1_colz_ff;
   logic                 s1_eold_ff;
   logic                 s1_enew_ff;
   logic                 byp_ff;
   logic [2*PIX_W-1:0]   byp_data_ff;
   logic [2*PIX_W-1:0]   mem_q_ff;
   logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];

   // stage 2 and output
   logic                 s2_v_ff;
   logic [BOX_SUM_W-1:0] s2_sum_ff;
   logic                 s2_re_ff;
   logic                 s2_fe_ff;
   logic                 o_v_ff;
   logic                 o_re_ff;
   logic                 o_fe_ff;

   logic o_en, s2_en, s1_en, accept, take, s1_fire, s1_emit, s1_writes;
   logic [1:0]         kind;
   logic               col_last;
   logic [EW-1:0]      col_next;
   logic [ROW_W-1:0]   row_next;
   logic [2*PIX_W-1:0] rd_data;
   logic [2*PIX_W-1:0] wr_data;
   logic [PIX_W-1:0]   top, mid, bot;
   logic [BOX_SUM_W-1:0] box_sum;
   win_ctrl_type       win_ctrl;
   logic               re, fe;
   logic [EW-1:0]      out_col_next;
   logic [FRAME_H_W-1:0] out_row_next;

   // effective frame size
   assign fw_ext = EW'(frame_width_ff);
   always_comb begin
      eff_w = fw_ext;
      if (fw_ext == '0) begin
         eff_w = EW'(1);
      end else if (fw_ext > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end
      eff_h = frame_height_ff;
      if (frame_height_ff == '0) begin
         eff_h = FRAME_H_W'(1);
      end else if (frame_height_ff > HEIGHT_MAX) begin
         eff_h = HEIGHT_MAX;
      end
   end

   // pipeline flow
   assign o_en       = !o_v_ff || rsp_tready;
   assign s2_en      = !s2_v_ff || o_en;
   assign s1_en      = !s1_v_ff || s2_en;
   assign req_tready = s1_en;
   assign accept     = req_tvalid && req_tready;
   assign s1_fire    = s1_v_ff && s2_en;

   // input side decision
   always_comb begin
      take      = 1'b0;
      kind      = KIND_FILL0;
      phase_in  = phase_ff;
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      col_next  = EW'(in_col_ff) + EW'(1);
      col_last  = col_next >= eff_w;
      row_next  = in_row_ff + ROW_W'(1);
      case (phase_ff)
         PHASE_TAKE: begin
            take = !req_tuser;
            kind = (in_row_ff == '0) ? KIND_FILL0 : KIND_PIX;
         end
         PHASE_FLUSH: begin
            take = req_tuser;
            kind = KIND_FLUSH;
         end
         PHASE_FINAL: begin
            take = req_tuser;
            kind = KIND_FINAL;
         end
         default: begin
            take = 1'b0;
            kind = KIND_FINAL;
         end
      endcase
      if (accept && take) begin
         if (kind == KIND_FINAL) begin
            phase_in  = PHASE_TAKE;
            in_col_in = '0;
            in_row_in = '0;
         end else if (col_last) begin
            in_col_in = '0;
            if (phase_ff == PHASE_TAKE) begin
               in_row_in = row_next;
               if (row_next >= ROW_W'(eff_h)) begin
                  phase_in = PHASE_FLUSH;
               end
            end else begin
               phase_in = PHASE_FINAL;
            end
         end else begin
            in_col_in = col_next[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
         phase_ff        <= PHASE_TAKE;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
      end else if (csr_we) begin
         if (csr_index == REG_FRAME_WIDTH) begin
            frame_width_ff <= csr_wdata[FRAME_W_W-1:0];
         end else begin
            frame_height_ff <= csr_wdata;
         end
         phase_ff   <= PHASE_TAKE;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // stage 1 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_en) begin
         s1_v_ff <= accept && take;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= kind;
         s1_x_ff     <= in_col_ff;
         s1_pix_ff   <= req_tdata;
         s1_colz_ff  <= (in_col_ff == '0);
         s1_eold_ff  <= (kind == KIND_FINAL) ||
                        ((in_col_ff == '0) && (in_row_ff >= ROW_W'(2)));
         s1_enew_ff  <= (kind != KIND_FINAL) && (in_col_ff != '0) && (in_row_ff != '0);
         byp_ff      <= s1_fire && s1_writes && (s1_x_ff == in_col_ff);
         byp_data_ff <= wr_data;
      end
   end

   // line store: upper row in the high byte, middle row in the low byte
   always_ff @(posedge clock) begin
      if (s1_fire && s1_writes) begin
         line_mem[s1_x_ff] <= wr_data;
      end
      if (accept) begin
         mem_q_ff <= line_mem[in_col_ff];
      end
   end

   // stage 1 logic
   assign rd_data   = byp_ff ? byp_data_ff : mem_q_ff;
   assign s1_writes = (s1_kind_ff == KIND_FILL0) || (s1_kind_ff == KIND_PIX);
   assign top = (s1_kind_ff == KIND_FILL0) ? s1_pix_ff : rd_data[2*PIX_W-1:PIX_W];
   assign mid = (s1_kind_ff == KIND_FILL0) ? s1_pix_ff : rd_data[PIX_W-1:0];
   assign bot = (s1_kind_ff == KIND_FLUSH) ? mid : s1_pix_ff;
   assign wr_data = {mid, s1_pix_ff};

   assign win_ctrl.fill    = s1_fire && (s1_kind_ff != KIND_FINAL) && s1_colz_ff;
   assign win_ctrl.shift   = s1_fire && (s1_kind_ff != KIND_FINAL) && !s1_colz_ff;
   assign win_ctrl.use_new = s1_enew_ff;

   bf3_window u_window (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (win_ctrl),
      .top     (top),
      .mid     (mid),
      .bot     (bot),
      .box_sum (box_sum)
   );

   // output position
   assign s1_emit      = s1_eold_ff || s1_enew_ff;
   assign out_col_next = EW'(out_col_ff) + EW'(1);
   assign out_row_next = FRAME_H_W'(out_row_ff) + FRAME_H_W'(1);
   assign re           = out_col_next >= eff_w;
   assign fe           = re && (out_row_next >= eff_h);

   always_comb begin
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (s1_fire && s1_emit) begin
         if (re) begin
            out_col_in = '0;
            out_row_in = fe ? '0 : out_row_next[OUT_ROW_W-1:0];
         end else begin
            out_col_in = out_col_next[IDX_W-1:0];
         end
      end
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_en) begin
         s2_v_ff <= s1_fire && s1_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_sum_ff <= box_sum;
         s2_re_ff  <= re;
         s2_fe_ff  <= fe;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (o_en) begin
         o_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_en) begin
         o_re_ff <= s2_re_ff;
         o_fe_ff <= s2_fe_ff;
      end
   end

   bf3_scaler u_scaler (
      .clock   (clock),
      .enable  (o_en),
      .box_sum (s2_sum_ff),
      .value   (rsp_tdata)
   );

   assign rsp_tvalid = o_v_ff;
   assign rsp_tlast  = o_re_ff;
   assign rsp_tuser  = o_fe_ff;

endmodule
